@@ rtl/assert_macros.svh @@
// assertion macros shared by the scanner modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define STSCAN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on every rising edge, reset included
`define STSCAN_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ rtl/stscan_pkg.sv @@
// types, token codes and keyword table of the source token scanner
// no dependencies
`default_nettype none

package stscan_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_SLASH, MODE_LCOM, MODE_BCOM, MODE_BSTAR, MODE_OP, MODE_STR,
        MODE_IDENT, MODE_INT, MODE_DOT, MODE_FRAC, MODE_E, MODE_ESIGN, MODE_EXP,
        MODE_ERR
    } scan_mode_t;

    typedef enum logic [1:0] {OP_BANG, OP_EQUAL, OP_LESS, OP_GREATER} op_code_t;

    localparam logic [5:0] KIND_LPAREN    = 6'd0;
    localparam logic [5:0] KIND_RPAREN    = 6'd1;
    localparam logic [5:0] KIND_LBRACE    = 6'd2;
    localparam logic [5:0] KIND_RBRACE    = 6'd3;
    localparam logic [5:0] KIND_SEMI      = 6'd4;
    localparam logic [5:0] KIND_COMMA     = 6'd5;
    localparam logic [5:0] KIND_DOT       = 6'd6;
    localparam logic [5:0] KIND_MINUS     = 6'd7;
    localparam logic [5:0] KIND_PLUS      = 6'd8;
    localparam logic [5:0] KIND_SLASH     = 6'd9;
    localparam logic [5:0] KIND_STAR      = 6'd10;
    localparam logic [5:0] KIND_BANG      = 6'd11;
    localparam logic [5:0] KIND_EQUAL     = 6'd13;
    localparam logic [5:0] KIND_LESS      = 6'd15;
    localparam logic [5:0] KIND_GREATER   = 6'd17;
    localparam logic [5:0] KIND_STRING    = 6'd19;
    localparam logic [5:0] KIND_NUMBER    = 6'd20;
    localparam logic [5:0] KIND_IDENT     = 6'd21;
    localparam logic [5:0] KIND_KW_BASE   = 6'd22;
    localparam logic [5:0] KIND_END       = 6'd39;
    localparam logic [5:0] KIND_BAD_CHAR  = 6'd40;
    localparam logic [5:0] KIND_OPEN_STR  = 6'd41;

    localparam int NUM_KW  = 17;
    localparam int KW_CHARS_MAX = 8;
    localparam int MAX_RESULTS = 4;

    localparam logic [16:0] LEN_MAX = 17'h10000;
    localparam logic [16:0] KW_ALL  = 17'h1FFFF;

    localparam logic [7:0] KW_CHARS [NUM_KW][KW_CHARS_MAX] = '{
        '{"a", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "l", "a", "s", "s", 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
        '{"f", "u", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "u", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"s", "u", "p", "e", "r", 8'h00, 8'h00, 8'h00},
        '{"t", "h", "i", "s", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"e", "x", "t", "e", "n", "d", "s", 8'h00}
    };

    // first field in the highest bits
    typedef struct packed {
        logic [15:0] length;
        logic [15:0] start;
        logic [15:0] line;
        logic [5:0]  kind;
    } token_t;

    typedef struct packed {
        logic                        valid;
        logic [1:0]                  last_idx;
        token_t [MAX_RESULTS-1:0]    tok;
    } batch_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic [16:0] kw_update(input logic [16:0] mask,
                                              input logic [3:0] idlen,
                                              input logic [7:0] c);
        logic [16:0] m;
        m = mask;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (idlen[3] || (KW_CHARS[k][idlen[2:0]] != c))
            begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    function automatic logic [5:0] ident_kind(input logic [16:0] mask,
                                              input logic [3:0] idlen);
        logic [5:0] kind;
        kind = KIND_IDENT;
        if (!idlen[3])
        begin
            for (int k = NUM_KW - 1; k >= 0; k--)
            begin
                if (mask[k] && (KW_CHARS[k][idlen[2:0]] == 8'h00))
                begin
                    kind = KIND_KW_BASE + 6'(k);
                end
            end
        end
        return kind;
    endfunction

    function automatic logic [5:0] op_kind(input op_code_t op, input logic two);
        logic [5:0] base;
        case (op)
            OP_BANG:  base = KIND_BANG;
            OP_EQUAL: base = KIND_EQUAL;
            OP_LESS:  base = KIND_LESS;
            default:  base = KIND_GREATER;
        endcase
        return base + {5'd0, two};
    endfunction

    function automatic logic [15:0] sat_len(input logic [16:0] len);
        return len[16] ? 16'hFFFF : len[15:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/stscan_core.sv @@
// input register, scanner state and per-byte token decode
// depends on stscan_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module stscan_core #(
    parameter int OFFSET_BITS = 16,
    parameter int LINE_BITS   = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_eos,
    input  wire logic              load_ok,
    output stscan_pkg::batch_t     batch
);

    localparam logic [OFFSET_BITS-1:0] OFF_ONE  = OFFSET_BITS'(1);
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

    logic                         s1_valid_reg;
    logic [7:0]                   s1_byte_reg;
    logic                         s1_eos_reg;
    logic                         advance;

    stscan_pkg::scan_mode_t       mode_reg, f_mode;
    stscan_pkg::op_code_t         op_reg, f_op;
    logic [LINE_BITS-1:0]         line_reg, line_next;
    logic [OFFSET_BITS-1:0]       off_reg, begin_reg, f_begin, off_prev, off_succ;
    logic [16:0]                  cand_reg, f_cand;
    logic [3:0]                   idlen_reg, f_idlen, idlen_inc;
    logic [16:0]                  len_reg, f_len, len_grow, len_m1;
    logic                         line_inc;

    // tokens decided while feeding the byte
    logic                         pre0_v, pre1_v, idl_v;
    logic [5:0]                   pre0_k, pre1_k, idl_k;
    logic [OFFSET_BITS-1:0]       pre0_s, pre1_s;
    logic [16:0]                  pre0_l;

    logic [15:0]                  line_a16, line_b16;
    stscan_pkg::token_t           ctok [6];
    logic [5:0]                   cvld;

    logic [7:0] c;
    assign c = s1_byte_reg;

    assign advance  = s1_valid_reg && load_ok;
    assign in_ready = !s1_valid_reg || load_ok;

    assign off_prev  = off_reg - OFF_ONE;
    assign off_succ  = off_reg + OFF_ONE;
    assign len_grow  = (len_reg >= stscan_pkg::LEN_MAX) ? len_reg : len_reg + 17'd1;
    assign len_m1    = len_reg - 17'd1;
    assign idlen_inc = (idlen_reg == 4'hF) ? idlen_reg : idlen_reg + 4'd1;

    always_comb
    begin
        logic run_idle;
        run_idle = 1'b0;
        f_mode   = mode_reg;
        f_op     = op_reg;
        f_begin  = begin_reg;
        f_cand   = cand_reg;
        f_idlen  = idlen_reg;
        f_len    = len_reg;
        line_inc = 1'b0;
        pre0_v = 1'b0; pre0_k = stscan_pkg::KIND_NUMBER; pre0_s = begin_reg; pre0_l = len_reg;
        pre1_v = 1'b0; pre1_k = stscan_pkg::KIND_DOT;    pre1_s = off_prev;
        idl_v  = 1'b0; idl_k  = stscan_pkg::KIND_BAD_CHAR;

        case (mode_reg)
            stscan_pkg::MODE_IDLE:
            begin
                run_idle = 1'b1;
            end
            stscan_pkg::MODE_SLASH:
            begin
                if (c == "/")
                begin
                    f_mode = stscan_pkg::MODE_LCOM;
                end
                else if (c == "*")
                begin
                    f_mode = stscan_pkg::MODE_BCOM;
                end
                else
                begin
                    pre0_v = 1'b1; pre0_k = stscan_pkg::KIND_SLASH; pre0_l = 17'd1;
                    run_idle = 1'b1;
                end
            end
            stscan_pkg::MODE_LCOM:
            begin
                if (c == 8'h0A)
                begin
                    line_inc = 1'b1;
                    f_mode   = stscan_pkg::MODE_IDLE;
                end
            end
            stscan_pkg::MODE_BCOM, stscan_pkg::MODE_BSTAR:
            begin
                if (c == "/" && mode_reg == stscan_pkg::MODE_BSTAR)
                begin
                    f_mode = stscan_pkg::MODE_IDLE;
                end
                else
                begin
                    line_inc = (c == 8'h0A);
                    f_mode = (c == "*") ? stscan_pkg::MODE_BSTAR : stscan_pkg::MODE_BCOM;
                end
            end
            stscan_pkg::MODE_OP:
            begin
                pre0_v = 1'b1;
                if (c == "=")
                begin
                    pre0_k = stscan_pkg::op_kind(op_reg, 1'b1); pre0_l = 17'd2;
                    f_mode = stscan_pkg::MODE_IDLE;
                    f_op   = stscan_pkg::OP_BANG;
                end
                else
                begin
                    pre0_k = stscan_pkg::op_kind(op_reg, 1'b0); pre0_l = 17'd1;
                    run_idle = 1'b1;
                end
            end
            stscan_pkg::MODE_STR:
            begin
                f_len    = len_grow;
                line_inc = (c == 8'h0A);
                if (c == "\"")
                begin
                    pre0_v = 1'b1; pre0_k = stscan_pkg::KIND_STRING; pre0_l = len_grow;
                    f_mode = stscan_pkg::MODE_IDLE;
                end
            end
            stscan_pkg::MODE_IDENT:
            begin
                if (stscan_pkg::is_alpha(c) || stscan_pkg::is_digit(c))
                begin
                    f_len   = len_grow;
                    f_cand  = stscan_pkg::kw_update(cand_reg, idlen_reg, c);
                    f_idlen = idlen_inc;
                end
                else
                begin
                    pre0_v = 1'b1;
                    pre0_k = stscan_pkg::ident_kind(cand_reg, idlen_reg);
                    run_idle = 1'b1;
                end
            end
            stscan_pkg::MODE_INT, stscan_pkg::MODE_FRAC:
            begin
                if (stscan_pkg::is_digit(c))
                begin
                    f_len = len_grow;
                end
                else if (c == "E")
                begin
                    f_len = len_grow; f_mode = stscan_pkg::MODE_E;
                end
                else if (c == "." && mode_reg == stscan_pkg::MODE_INT)
                begin
                    f_len = len_grow; f_mode = stscan_pkg::MODE_DOT;
                end
                else
                begin
                    pre0_v = 1'b1;
                    run_idle = 1'b1;
                end
            end
            stscan_pkg::MODE_DOT:
            begin
                if (stscan_pkg::is_digit(c))
                begin
                    f_len = len_grow; f_mode = stscan_pkg::MODE_FRAC;
                end
                else
                begin
                    // number without its dot, then the dot on its own
                    pre0_v = 1'b1; pre0_l = len_m1;
                    pre1_v = 1'b1;
                    run_idle = 1'b1;
                end
            end
            stscan_pkg::MODE_E:
            begin
                if (c == "+" || c == "-")
                begin
                    f_len = len_grow; f_mode = stscan_pkg::MODE_ESIGN;
                end
                else if (stscan_pkg::is_digit(c))
                begin
                    f_len = len_grow; f_mode = stscan_pkg::MODE_EXP;
                end
                else
                begin
                    // the E was not an exponent: it opens an identifier
                    pre0_v = 1'b1; pre0_l = len_m1;
                    if (stscan_pkg::is_alpha(c))
                    begin
                        f_mode  = stscan_pkg::MODE_IDENT;
                        f_begin = off_prev;
                        f_len   = 17'd2;
                        f_idlen = 4'd2;
                        f_cand  = '0;
                    end
                    else
                    begin
                        pre1_v = 1'b1; pre1_k = stscan_pkg::KIND_IDENT;
                        run_idle = 1'b1;
                    end
                end
            end
            stscan_pkg::MODE_ESIGN, stscan_pkg::MODE_EXP:
            begin
                if (stscan_pkg::is_digit(c))
                begin
                    f_len = len_grow; f_mode = stscan_pkg::MODE_EXP;
                end
                else
                begin
                    pre0_v = 1'b1;
                    run_idle = 1'b1;
                end
            end
            default:
            begin
                // error: bytes dropped until end of source
            end
        endcase

        if (run_idle)
        begin
            f_mode = stscan_pkg::MODE_IDLE;
            f_op   = stscan_pkg::OP_BANG;
            case (c)
                " ", 8'h0D, 8'h09: ;
                8'h0A: line_inc = 1'b1;
                "(": begin idl_v = 1'b1; idl_k = stscan_pkg::KIND_LPAREN; end
                ")": begin idl_v = 1'b1; idl_k = stscan_pkg::KIND_RPAREN; end
                "{": begin idl_v = 1'b1; idl_k = stscan_pkg::KIND_LBRACE; end
                "}": begin idl_v = 1'b1; idl_k = stscan_pkg::KIND_RBRACE; end
                ";": begin idl_v = 1'b1; idl_k = stscan_pkg::KIND_SEMI;   end
                ",": begin idl_v = 1'b1; idl_k = stscan_pkg::KIND_COMMA;  end
                ".": begin idl_v = 1'b1; idl_k = stscan_pkg::KIND_DOT;    end
                "-": begin idl_v = 1'b1; idl_k = stscan_pkg::KIND_MINUS;  end
                "+": begin idl_v = 1'b1; idl_k = stscan_pkg::KIND_PLUS;   end
                "*": begin idl_v = 1'b1; idl_k = stscan_pkg::KIND_STAR;   end
                "/":
                begin
                    f_mode = stscan_pkg::MODE_SLASH; f_begin = off_reg; f_len = 17'd1;
                end
                "!", "=", "<", ">":
                begin
                    f_mode  = stscan_pkg::MODE_OP;
                    f_begin = off_reg;
                    f_len   = 17'd1;
                    f_op    = (c == "!") ? stscan_pkg::OP_BANG :
                              (c == "=") ? stscan_pkg::OP_EQUAL :
                              (c == "<") ? stscan_pkg::OP_LESS : stscan_pkg::OP_GREATER;
                end
                "\"":
                begin
                    f_mode = stscan_pkg::MODE_STR; f_begin = off_reg; f_len = 17'd1;
                end
                default:
                begin
                    if (stscan_pkg::is_digit(c))
                    begin
                        f_mode = stscan_pkg::MODE_INT; f_begin = off_reg; f_len = 17'd1;
                    end
                    else if (stscan_pkg::is_alpha(c))
                    begin
                        f_mode  = stscan_pkg::MODE_IDENT;
                        f_begin = off_reg;
                        f_len   = 17'd1;
                        f_idlen = 4'd1;
                        f_cand  = stscan_pkg::kw_update(stscan_pkg::KW_ALL, 4'd0, c);
                    end
                    else
                    begin
                        idl_v  = 1'b1;
                        f_mode = stscan_pkg::MODE_ERR;
                    end
                end
            endcase
        end
    end

    assign line_next = (line_inc && line_reg != '1) ? line_reg + LINE_ONE : line_reg;
    assign line_a16  = (32'(line_reg) >= 32'hFFFF) ? 16'hFFFF : 16'(line_reg);
    assign line_b16  = (32'(line_next) >= 32'hFFFF) ? 16'hFFFF : 16'(line_next);

    // candidate list in emit order, then the first four are kept
    always_comb
    begin
        logic [2:0] cnt;
        stscan_pkg::token_t fl0, fl1;
        logic fl0_v, fl1_v;

        fl0_v = s1_eos_reg;
        fl1_v = 1'b0;
        fl0 = '{length: stscan_pkg::sat_len(f_len), start: 16'(f_begin),
                line: line_b16, kind: stscan_pkg::KIND_NUMBER};
        fl1 = '{length: 16'd1, start: 16'(off_reg), line: line_b16,
                kind: stscan_pkg::KIND_DOT};
        case (f_mode)
            stscan_pkg::MODE_SLASH:
            begin
                fl0.kind = stscan_pkg::KIND_SLASH; fl0.length = 16'd1;
            end
            stscan_pkg::MODE_OP:
            begin
                fl0.kind = stscan_pkg::op_kind(f_op, 1'b0); fl0.length = 16'd1;
            end
            stscan_pkg::MODE_STR:   fl0.kind = stscan_pkg::KIND_OPEN_STR;
            stscan_pkg::MODE_IDENT: fl0.kind = stscan_pkg::ident_kind(f_cand, f_idlen);
            stscan_pkg::MODE_INT, stscan_pkg::MODE_FRAC,
            stscan_pkg::MODE_ESIGN, stscan_pkg::MODE_EXP: ;
            stscan_pkg::MODE_DOT:
            begin
                fl0.length = stscan_pkg::sat_len(f_len - 17'd1);
                fl1_v = s1_eos_reg;
            end
            stscan_pkg::MODE_E:
            begin
                fl0.length = stscan_pkg::sat_len(f_len - 17'd1);
                fl1.kind = stscan_pkg::KIND_IDENT;
                fl1_v = s1_eos_reg;
            end
            default: fl0_v = 1'b0;
        endcase

        ctok[0] = '{length: stscan_pkg::sat_len(pre0_l), start: 16'(pre0_s),
                    line: line_a16, kind: pre0_k};
        ctok[1] = '{length: 16'd1, start: 16'(pre1_s), line: line_a16, kind: pre1_k};
        ctok[2] = '{length: 16'd1, start: 16'(off_reg), line: line_a16, kind: idl_k};
        ctok[3] = fl0;
        ctok[4] = fl1;
        ctok[5] = '{length: 16'd0, start: 16'(off_succ), line: line_b16,
                    kind: stscan_pkg::KIND_END};
        cvld = {s1_eos_reg, fl1_v, fl0_v, idl_v, pre1_v, pre0_v};

        cnt = 3'd0;
        batch.tok = '0;
        for (int i = 0; i < 6; i++)
        begin
            if (cvld[i] && cnt < 3'(stscan_pkg::MAX_RESULTS))
            begin
                batch.tok[cnt[1:0]] = ctok[i];
                cnt = cnt + 3'd1;
            end
        end
        batch.valid    = advance && (cnt != 3'd0);
        batch.last_idx = 2'(cnt - 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= in_byte;
            s1_eos_reg  <= in_eos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stscan_pkg::MODE_IDLE;
            op_reg    <= stscan_pkg::OP_BANG;
            line_reg  <= LINE_ONE;
            off_reg   <= '0;
            begin_reg <= '0;
            cand_reg  <= stscan_pkg::KW_ALL;
            idlen_reg <= '0;
            len_reg   <= '0;
        end
        else if (advance)
        begin
            if (s1_eos_reg)
            begin
                mode_reg  <= stscan_pkg::MODE_IDLE;
                op_reg    <= stscan_pkg::OP_BANG;
                line_reg  <= LINE_ONE;
                off_reg   <= '0;
                begin_reg <= '0;
                cand_reg  <= stscan_pkg::KW_ALL;
                idlen_reg <= '0;
                len_reg   <= '0;
            end
            else
            begin
                mode_reg  <= f_mode;
                op_reg    <= f_op;
                line_reg  <= line_next;
                off_reg   <= off_succ;
                begin_reg <= f_begin;
                cand_reg  <= f_cand;
                idlen_reg <= f_idlen;
                len_reg   <= f_len;
            end
        end
    end

    `STSCAN_ASSERT(a_eos_restarts, (advance && s1_eos_reg) |=> (mode_reg == stscan_pkg::MODE_IDLE && off_reg == '0 && line_reg == LINE_ONE), "scanner not back at start after end of source")
    `STSCAN_ASSERT(a_error_holds, (mode_reg == stscan_pkg::MODE_ERR && !(advance && s1_eos_reg)) |=> (mode_reg == stscan_pkg::MODE_ERR), "error mode left before end of source")
    `STSCAN_ASSERT(a_eos_gives_batch, (advance && s1_eos_reg) |-> batch.valid, "end of source produced no tokens")

endmodule

`default_nettype wire

@@ rtl/stscan_out.sv @@
// result register holding one byte's tokens, drained one per cycle while out_ready is high
// depends on stscan_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module stscan_out (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  stscan_pkg::batch_t  batch,
    output logic                load_ok,
    output logic                out_valid,
    input  wire logic           out_ready,
    output stscan_pkg::token_t  out_tok,
    output logic                out_last
);

    logic                                         busy_reg;
    logic [1:0]                                   idx_reg;
    logic [1:0]                                   last_idx_reg;
    stscan_pkg::token_t [stscan_pkg::MAX_RESULTS-1:0] tok_reg;

    assign out_valid = busy_reg;
    assign out_last  = (idx_reg == last_idx_reg);
    assign out_tok   = tok_reg[idx_reg];
    assign load_ok   = !busy_reg || (out_ready && out_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load_ok)
        begin
            busy_reg <= batch.valid;
            idx_reg  <= '0;
        end
        else if (out_ready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && batch.valid)
        begin
            tok_reg      <= batch.tok;
            last_idx_reg <= batch.last_idx;
        end
    end

    `STSCAN_ASSERT(a_index_in_batch, busy_reg |-> (idx_reg <= last_idx_reg), "drain index past end of batch")
    `STSCAN_ASSERT(a_stall_holds, (busy_reg && !out_ready) |=> (busy_reg && $stable(idx_reg)), "token moved on while stalled")
    `STSCAN_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |=> !busy_reg, "result shown during reset")

endmodule

`default_nettype wire

@@ rtl/source_token_scanner.sv @@
// top level of the source token scanner: byte stream in, token stream out
// depends on stscan_pkg, stscan_core and stscan_out
//
// usage
//   slave side takes one source byte per request: tdata[7:0] is the byte and
//   tlast marks the final byte of the source. master side gives one token per
//   request: kind, line, start offset and length in tdata, tlast on the final
//   token caused by a given byte.
// timing
//   a byte is registered on acceptance and decoded from that register; up to four
//   tokens land in the result register once it can take them, and the first of
//   them is shown straight from that register. throughput is one byte per cycle
//   while each byte yields at most one token and tready stays high; a byte that
//   yields more tokens holds the input until the result register has drained
//   them, one token per cycle.
// reset
//   rst_n clears both registers and starts a new source: line 1, offset 0.
//   after end of source the scanner returns to the same start state.
// stalls
//   when the receiver holds tready low the result register keeps its token,
//   the decode register waits behind it and s_axis_tready falls when it is full.
`default_nettype none

module source_token_scanner #(
    parameter int OFFSET_BITS = 16,
    parameter int LINE_BITS   = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] source_byte
    input  wire logic        s_axis_tlast,   // end_of_source
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [5:0] token_kind, [21:6] token_line,
                                             // [37:22] token_start, [53:38] token_length
    output logic             m_axis_tlast    // last_of_run
);

    stscan_pkg::batch_t  batch;
    stscan_pkg::token_t  tok;
    logic                load_ok;

    // byte register, scanner state and token decode
    stscan_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_eos   (s_axis_tlast),
        .load_ok  (load_ok),
        .batch    (batch)
    );

    // result register, one token per request
    stscan_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .batch     (batch),
        .load_ok   (load_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tok   (tok),
        .out_last  (m_axis_tlast)
    );

    // pad to whole bytes
    assign m_axis_tdata = {2'b00, tok};

endmodule

`default_nettype wire
